### design/mhtu_pkg.sv
// shared types and constants of the homogeneous matrix transform unit
`timescale 1ns / 1ps
package mhtu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        CMD_WR_CUR  = 2'd0,
        CMD_WR_OP   = 2'd1,
        CMD_COMBINE = 2'd2,
        CMD_XFORM   = 2'd3
    } mhtu_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMB_ZERO,
        ST_CMB_MUL,
        ST_CMB_ACC,
        ST_CMB_STORE,
        ST_CMB_SWAP,
        ST_XF_LOAD,
        ST_XF_MUL,
        ST_XF_ACC,
        ST_XF_STORE,
        ST_XF_CHECK,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_STORE,
        ST_XF_OUT
    } mhtu_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC_ZERO,
        OP_ACC_TRANS,
        OP_MUL_CMB,
        OP_MUL_XF,
        OP_ACC_ADD,
        OP_STORE_CMB,
        OP_SWAP,
        OP_STORE_V,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_STORE,
        OP_OUT_LOAD
    } mhtu_op_t;

    typedef struct packed {
        logic       accept;
        mhtu_op_t   op;
        logic [3:0] elem;
        logic [1:0] kk;
        logic [1:0] lane;
    } mhtu_ctl_t;

    typedef struct packed {
        logic w_zero;
    } mhtu_stat_t;

endpackage

### design/mhtu_ctrl.sv
// controller state machine of the homogeneous matrix transform unit
`timescale 1ns / 1ps
module mhtu_ctrl #(
    parameter int DIV_STEPS = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    output logic               out_valid,
    input  logic               out_ready,
    input  mhtu_pkg::mhtu_stat_t stat,
    output mhtu_pkg::mhtu_ctl_t  ctl
);
    import mhtu_pkg::*;

    localparam int DCW = $clog2(DIV_STEPS);

    mhtu_state_t state_reg, state_next;
    logic [3:0] elem_reg, elem_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] lane_reg, lane_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elem_reg      <= '0;
            k_reg         <= '0;
            lane_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elem_reg      <= elem_next;
            k_reg         <= k_next;
            lane_reg      <= lane_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        elem_next      = elem_reg;
        k_next         = k_reg;
        lane_next      = lane_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        ctl.accept     = accept;
        ctl.op         = OP_NONE;
        ctl.elem       = elem_reg;
        ctl.kk         = k_reg;
        ctl.lane       = lane_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                elem_next = '0;
                k_next    = '0;
                lane_next = '0;
                if (accept && cmd == CMD_COMBINE)
                begin
                    state_next = ST_CMB_ZERO;
                end
                else if (accept && cmd == CMD_XFORM)
                begin
                    state_next = ST_XF_LOAD;
                end
            end
            ST_CMB_ZERO:
            begin
                ctl.op     = OP_ACC_ZERO;
                k_next     = '0;
                state_next = ST_CMB_MUL;
            end
            ST_CMB_MUL:
            begin
                ctl.op     = OP_MUL_CMB;
                state_next = ST_CMB_ACC;
            end
            ST_CMB_ACC:
            begin
                ctl.op = OP_ACC_ADD;
                k_next = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? ST_CMB_STORE : ST_CMB_MUL;
            end
            ST_CMB_STORE:
            begin
                ctl.op     = OP_STORE_CMB;
                elem_next  = elem_reg + 4'd1;
                state_next = (elem_reg == 4'd15) ? ST_CMB_SWAP : ST_CMB_ZERO;
            end
            ST_CMB_SWAP:
            begin
                ctl.op     = OP_SWAP;
                state_next = ST_IDLE;
            end
            ST_XF_LOAD:
            begin
                ctl.op     = OP_ACC_TRANS;
                k_next     = '0;
                state_next = ST_XF_MUL;
            end
            ST_XF_MUL:
            begin
                ctl.op     = OP_MUL_XF;
                state_next = ST_XF_ACC;
            end
            ST_XF_ACC:
            begin
                ctl.op = OP_ACC_ADD;
                k_next = k_reg + 2'd1;
                state_next = (k_reg == 2'd2) ? ST_XF_STORE : ST_XF_MUL;
            end
            ST_XF_STORE:
            begin
                ctl.op     = OP_STORE_V;
                elem_next  = elem_reg + 4'd1;
                state_next = (elem_reg[1:0] == 2'd3) ? ST_XF_CHECK : ST_XF_LOAD;
            end
            ST_XF_CHECK:
            begin
                lane_next  = '0;
                state_next = stat.w_zero ? ST_XF_OUT : ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                ctl.op     = OP_DIV_INIT;
                dcnt_next  = '0;
                state_next = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                ctl.op    = OP_DIV_STEP;
                dcnt_next = dcnt_reg + DCW'(1);
                if (dcnt_reg == DCW'(DIV_STEPS - 1))
                begin
                    state_next = ST_DIV_STORE;
                end
            end
            ST_DIV_STORE:
            begin
                ctl.op     = OP_DIV_STORE;
                lane_next  = lane_reg + 2'd1;
                state_next = (lane_reg == 2'd2) ? ST_XF_OUT : ST_DIV_INIT;
            end
            ST_XF_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.op         = OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_out_from_xf: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_XF_OUT))
        else $error("result raised outside output state");
    a_lane_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_INIT || state_reg == ST_DIV_STEP ||
         state_reg == ST_DIV_STORE) |-> lane_reg != 2'd3)
        else $error("divide lane out of range");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_STORE |-> $past(dcnt_reg) == DCW'(DIV_STEPS - 1))
        else $error("divide ended early");
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XF_OUT && out_valid_reg && !out_ready) |=> state_reg == ST_XF_OUT)
        else $error("result overwritten");
`endif

endmodule

### design/mhtu_dp.sv
// datapath of the homogeneous matrix transform unit: matrices, mac, divider
`timescale 1ns / 1ps
module mhtu_dp #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mhtu_pkg::mhtu_ctl_t         ctl,
    input  logic [1:0]                  cmd,
    input  logic [3:0]                  element_index,
    input  logic signed [WORD_BITS-1:0] element_value,
    input  logic signed [WORD_BITS-1:0] point_x,
    input  logic signed [WORD_BITS-1:0] point_y,
    input  logic signed [WORD_BITS-1:0] point_z,
    output mhtu_pkg::mhtu_stat_t        stat,
    output logic signed [WORD_BITS-1:0] out_x,
    output logic signed [WORD_BITS-1:0] out_y,
    output logic signed [WORD_BITS-1:0] out_z,
    output logic                        divide_fault
);
    import mhtu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W - F;
    localparam int AW = PW + 2;
    localparam int NW = W + F;
    localparam logic signed [W-1:0] ONE  = W'(1) << F;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] cur_reg [2][16];
    logic signed [W-1:0] op_reg [16];
    logic bank_reg;
    logic signed [W-1:0] px_reg, py_reg, pz_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [W-1:0] v_reg [4];
    logic [NW-1:0] num_reg, q_reg;
    logic [W-1:0]  rem_reg;
    logic          neg_reg;
    logic signed [W-1:0] quot_reg [3];
    logic signed [W-1:0] ox_reg, oy_reg, oz_reg;
    logic fault_reg;

    logic [1:0] row, col;
    logic signed [W-1:0] a_op, b_op, pt_op;
    logic signed [2*W-1:0] full, full_sh;
    logic signed [W-1:0] acc_sat;
    logic [AW-W:0] acc_hi;
    logic signed [W-1:0] num_v, den_v;
    logic [W-1:0] num_mag, den_mag;
    logic [W:0] rem2;
    logic ge;
    logic signed [W-1:0] q_sat;
    logic q_big_pos, q_big_neg;

    assign row = ctl.elem[1:0];
    assign col = ctl.elem[3:2];

    always_comb
    begin
        case (ctl.kk)
            2'd0: pt_op = px_reg;
            2'd1: pt_op = py_reg;
            default: pt_op = pz_reg;
        endcase
    end

    assign a_op    = cur_reg[bank_reg][{ctl.kk, row}];
    assign b_op    = (ctl.op == OP_MUL_XF) ? pt_op : op_reg[{col, ctl.kk}];
    assign full    = (2 * W)'(a_op) * (2 * W)'(b_op);
    assign full_sh = full >>> F;

    assign acc_hi  = acc_reg[AW-1:W-1];
    assign acc_sat = (acc_hi == '0 || acc_hi == '1) ? acc_reg[W-1:0]
                   : (acc_reg[AW-1] ? WMIN : WMAX);

    assign num_v   = v_reg[ctl.lane];
    assign den_v   = v_reg[3];
    assign num_mag = num_v[W-1] ? W'(-num_v) : W'(num_v);
    assign den_mag = den_v[W-1] ? W'(-den_v) : W'(den_v);
    assign rem2    = {rem_reg, num_reg[NW-1]};
    assign ge      = rem2 >= {1'b0, den_mag};

    assign q_big_pos = q_reg[NW-1:W-1] != '0;
    assign q_big_neg = (q_reg[NW-1:W] != '0) || (q_reg[W-1] && q_reg[W-2:0] != '0);
    assign q_sat = neg_reg ? (q_big_neg ? WMIN : W'(-q_reg[W-1:0]))
                           : (q_big_pos ? WMAX : q_reg[W-1:0]);

    assign stat.w_zero = (v_reg[3] == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                cur_reg[0][i] <= (i / 4 == i % 4) ? ONE : '0;
                cur_reg[1][i] <= (i / 4 == i % 4) ? ONE : '0;
                op_reg[i]     <= (i / 4 == i % 4) ? ONE : '0;
            end
        end
        else
        begin
            if (ctl.accept && cmd == CMD_WR_CUR)
            begin
                cur_reg[bank_reg][element_index] <= element_value;
            end
            if (ctl.accept && cmd == CMD_WR_OP)
            begin
                op_reg[element_index] <= element_value;
            end
            if (ctl.op == OP_STORE_CMB)
            begin
                cur_reg[~bank_reg][ctl.elem] <= acc_sat;
            end
            if (ctl.op == OP_SWAP)
            begin
                bank_reg <= ~bank_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            pz_reg <= point_z;
        end
        case (ctl.op)
            OP_ACC_ZERO:  acc_reg <= '0;
            OP_ACC_TRANS: acc_reg <= AW'(cur_reg[bank_reg][{2'd3, row}]);
            OP_MUL_CMB,
            OP_MUL_XF:    prod_reg <= full_sh[PW-1:0];
            OP_ACC_ADD:   acc_reg <= acc_reg + AW'(prod_reg);
            OP_STORE_V:   v_reg[row] <= acc_sat;
            OP_DIV_INIT:
            begin
                num_reg <= {num_mag, {F{1'b0}}};
                rem_reg <= '0;
                q_reg   <= '0;
                neg_reg <= num_v[W-1] ^ den_v[W-1];
            end
            OP_DIV_STEP:
            begin
                rem_reg <= ge ? W'(rem2 - {1'b0, den_mag}) : rem2[W-1:0];
                num_reg <= {num_reg[NW-2:0], 1'b0};
                q_reg   <= {q_reg[NW-2:0], ge};
            end
            OP_DIV_STORE: quot_reg[ctl.lane] <= q_sat;
            OP_OUT_LOAD:
            begin
                ox_reg    <= stat.w_zero ? '0 : quot_reg[0];
                oy_reg    <= stat.w_zero ? '0 : quot_reg[1];
                oz_reg    <= stat.w_zero ? '0 : quot_reg[2];
                fault_reg <= stat.w_zero;
            end
            default: ;
        endcase
    end

    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;
    assign divide_fault = fault_reg;

endmodule

### design/homogeneous_matrix_transform_unit_top.sv
// Homogeneous 4x4 matrix transform unit. A combine (current = current * operand) runs
// 16 elements of 4 multiply-accumulates on one shared multiplier, plus a clear and a
// store per element and a bank swap. A point transform runs 4 rows of 3 MACs with
// load and store and a w check, then, unless w is zero, three restoring divides in
// Q16.16 by default, one quotient bit per cycle, and an output load. One item is
// worked at a time; a new request is taken while a result waits in the output register.
`timescale 1ns / 1ps
module homogeneous_matrix_transform_unit_top #(
    parameter int FRAC_BITS = mhtu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = mhtu_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [3:0]                  element_index,
    input  logic signed [WORD_BITS-1:0] element_value,
    input  logic signed [WORD_BITS-1:0] point_x,
    input  logic signed [WORD_BITS-1:0] point_y,
    input  logic signed [WORD_BITS-1:0] point_z,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] out_x,
    output logic signed [WORD_BITS-1:0] out_y,
    output logic signed [WORD_BITS-1:0] out_z,
    output logic                        divide_fault
);
    import mhtu_pkg::*;

    mhtu_ctl_t  ctl;
    mhtu_stat_t stat;

    mhtu_ctrl #(
        .DIV_STEPS(WORD_BITS + FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    mhtu_dp #(
        .FRAC_BITS(FRAC_BITS),
        .WORD_BITS(WORD_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .cmd           (cmd),
        .element_index (element_index),
        .element_value (element_value),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .stat          (stat),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .divide_fault  (divide_fault)
    );

endmodule
